/* rtl/oip_pkg.sv */
`default_nettype none
package oip_pkg;

	// fixed field widths
	localparam int COORD_W = 11;
	localparam int SLOT_W = 8;
	localparam int REQ_W = 2;
	localparam int SLOT_SPAN = 2 ** SLOT_W;

	// request codes
	localparam logic [REQ_W-1:0] REQ_STORE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_PLANE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_SPHERE = 2'd2;

	// side codes
	localparam logic [1:0] SIDE_ZERO = 2'b00;
	localparam logic [1:0] SIDE_POS = 2'b01;
	localparam logic [1:0] SIDE_NEG = 2'b11;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int LVL_W = 3;

	typedef struct packed {
		logic empty;
		logic [LVL_W-1:0] level;
	} q_stat_t;

	// 2x2 minor pairs of the lifted 4x4 determinant, and term signs
	localparam int PAIR_I [6] = '{0, 0, 0, 1, 1, 2};
	localparam int PAIR_J [6] = '{1, 2, 3, 2, 3, 3};
	localparam logic [5:0] TERM_NEG = 6'b010010;

	function automatic logic [1:0] side_code(input logic neg, input logic nonzero);
		logic [1:0] r;
		if (neg) begin
			r = SIDE_NEG;
		end else if (nonzero) begin
			r = SIDE_POS;
		end else begin
			r = SIDE_ZERO;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/oip_front.sv */
`default_nettype none
module oip_front #(
	parameter int VERTEX_COUNT = 256,
	parameter int COORD_BITS = 11
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [oip_pkg::REQ_W-1:0] req_type,
	input wire logic [oip_pkg::SLOT_W-1:0] vertex_slot,
	input wire logic signed [oip_pkg::COORD_W-1:0] coord_x,
	input wire logic signed [oip_pkg::COORD_W-1:0] coord_y,
	input wire logic signed [oip_pkg::COORD_W-1:0] coord_z,
	input wire logic [oip_pkg::SLOT_W-1:0] corner_a,
	input wire logic [oip_pkg::SLOT_W-1:0] corner_b,
	input wire logic [oip_pkg::SLOT_W-1:0] corner_c,
	input wire logic [oip_pkg::SLOT_W-1:0] corner_d,
	input wire oip_pkg::q_stat_t qstat,
	output logic push,
	output logic [15*COORD_BITS:0] push_data
);
	import oip_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int VW = 3 * CB;
	localparam int EW = 15 * CB + 1;
	localparam int AW = $clog2(VERTEX_COUNT);

	logic [AW-1:0] slot_map [SLOT_SPAN];
	logic [VW-1:0] mem0 [VERTEX_COUNT];
	logic [VW-1:0] mem1 [VERTEX_COUNT];
	logic [VW-1:0] rd_s1 [4];
	logic [VW-1:0] p_s1;
	logic sph_s1;
	logic vld_s1;
	logic accept;
	logic is_query;
	logic wr_en;
	logic [VW-1:0] wr_word;

	// slot numbers wrap modulo the table size
	for (genvar g = 0; g < SLOT_SPAN; g++) begin : g_map
		assign slot_map[g] = AW'(g % VERTEX_COUNT);
	end

	// room for the item in flight plus the one being taken
	assign in_stall = (qstat.level == LVL_W'(QUEUE_DEPTH)) ||
		((qstat.level == LVL_W'(QUEUE_DEPTH - 1)) && vld_s1);
	assign accept = in_valid && !in_stall;
	assign is_query = (req_type == REQ_PLANE) || (req_type == REQ_SPHERE);
	assign wr_en = accept && (req_type == REQ_STORE);
	assign wr_word = {coord_z[CB-1:0], coord_y[CB-1:0], coord_x[CB-1:0]};

	// two copies of the table give four reads a cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem0[slot_map[vertex_slot]] <= wr_word;
		end
		rd_s1[0] <= mem0[slot_map[corner_a]];
		rd_s1[1] <= mem0[slot_map[corner_b]];
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem1[slot_map[vertex_slot]] <= wr_word;
		end
		rd_s1[2] <= mem1[slot_map[corner_c]];
		rd_s1[3] <= mem1[slot_map[corner_d]];
	end

	always_ff @(posedge clk) begin
		p_s1 <= wr_word;
		sph_s1 <= (req_type == REQ_SPHERE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept && is_query;
		end
	end

	always_comb begin
		push_data = '0;
		push_data[EW-1] = sph_s1;
		for (int c = 0; c < 3; c++) begin
			push_data[c*CB +: CB] = p_s1[c*CB +: CB];
			for (int k = 0; k < 4; k++) begin
				push_data[((k+1)*3+c)*CB +: CB] = rd_s1[k][c*CB +: CB];
			end
		end
	end

	assign push = vld_s1;

endmodule
`default_nettype wire

/* rtl/oip_queue.sv */
`default_nettype none
module oip_queue #(
	parameter int WIDTH = 166
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic [WIDTH-1:0] push_data,
	input wire logic pop,
	output logic [WIDTH-1:0] head_data,
	output oip_pkg::q_stat_t qstat
);
	import oip_pkg::*;

	logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [LVL_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + LVL_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - LVL_W'(1);
			end
		end
	end

	assign head_data = entry_q[rd_q];
	assign qstat.empty = (cnt_q == '0);
	assign qstat.level = cnt_q;

endmodule
`default_nettype wire

/* rtl/oip_back.sv */
`default_nettype none
module oip_back #(
	parameter int COORD_BITS = 11
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire oip_pkg::q_stat_t qstat,
	output logic pop,
	input wire logic [15*COORD_BITS:0] head_data,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [1:0] side
);
	import oip_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int EW = 15 * CB + 1;
	localparam int DW = CB + 1;
	localparam int PW = 2 * DW;
	localparam int MW = PW + 1;
	localparam int WW = PW + 2;
	localparam int T3 = DW + MW + 2;
	localparam int QW = DW + WW + 1;
	localparam int LO = QW / 2;
	localparam int HI = QW - LO;
	localparam int TW = MW + QW + 1;

	logic en;
	logic [8:1] vld_q;
	logic [8:1] sph_q;
	logic out_valid_q;
	logic [1:0] side_q;

	logic signed [CB-1:0] pv [3];
	logic signed [CB-1:0] vv [4][3];

	logic signed [DW-1:0] r_s1 [3][3];
	logic signed [DW-1:0] d_s1 [4][3];
	logic signed [DW-1:0] s_s1 [4][3];

	logic signed [PW-1:0] pm_s2 [6];
	logic signed [DW-1:0] rx_s2 [3];
	logic signed [PW-1:0] sd_s2 [4][3];
	logic signed [PW-1:0] pa_s2 [6];
	logic signed [PW-1:0] pb_s2 [6];
	logic signed [DW-1:0] dz_s2 [4];

	logic signed [MW-1:0] m_s3 [3];
	logic signed [DW-1:0] rx_s3 [3];
	logic signed [WW-1:0] w_s3 [4];
	logic signed [MW-1:0] p_s3 [6];
	logic signed [DW-1:0] dz_s3 [4];

	logic signed [DW+MW-1:0] t_s4 [3];
	logic signed [DW+WW-1:0] qa_s4 [6];
	logic signed [DW+WW-1:0] qb_s4 [6];
	logic signed [MW-1:0] p_s4 [6];

	logic signed [T3-1:0] det3;
	logic [1:0] pside_s5;
	logic [1:0] pside_s6;
	logic [1:0] pside_s7;
	logic [1:0] pside_s8;
	logic signed [QW-1:0] q_s5 [6];
	logic signed [MW-1:0] p_s5 [6];

	logic signed [MW+LO:0] ml_s6 [6];
	logic signed [MW+HI-1:0] mh_s6 [6];

	logic signed [TW-1:0] tm_s7 [6];
	logic signed [TW:0] u_s8 [3];
	logic signed [TW+1:0] det4;

	// whole pipe holds while a finished result waits
	assign en = !out_valid_q || !out_stall;
	assign pop = en && !qstat.empty;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			pv[c] = $signed(head_data[c*CB +: CB]);
			for (int k = 0; k < 4; k++) begin
				vv[k][c] = $signed(head_data[((k+1)*3+c)*CB +: CB]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q <= {vld_q[7:1], !qstat.empty};
			out_valid_q <= vld_q[8];
		end
	end

	assign det3 = t_s4[0] + t_s4[1] + t_s4[2];
	assign det4 = u_s8[0] + u_s8[1] + u_s8[2];

	always_ff @(posedge clk) begin
		if (en) begin
			sph_q <= {sph_q[7:1], head_data[EW-1]};

			// offsets: plane rows from the first corner, sphere rows from the point
			for (int c = 0; c < 3; c++) begin
				r_s1[0][c] <= pv[c] - vv[0][c];
				r_s1[1][c] <= vv[1][c] - vv[0][c];
				r_s1[2][c] <= vv[2][c] - vv[0][c];
				for (int k = 0; k < 4; k++) begin
					d_s1[k][c] <= vv[k][c] - pv[c];
					s_s1[k][c] <= vv[k][c] + pv[c];
				end
			end

			// products for the 3x3 minors and the lift
			pm_s2[0] <= r_s1[1][1] * r_s1[2][2];
			pm_s2[1] <= r_s1[2][1] * r_s1[1][2];
			pm_s2[2] <= r_s1[2][1] * r_s1[0][2];
			pm_s2[3] <= r_s1[0][1] * r_s1[2][2];
			pm_s2[4] <= r_s1[0][1] * r_s1[1][2];
			pm_s2[5] <= r_s1[1][1] * r_s1[0][2];
			for (int i = 0; i < 3; i++) begin
				rx_s2[i] <= r_s1[i][0];
			end
			for (int k = 0; k < 4; k++) begin
				dz_s2[k] <= d_s1[k][2];
				for (int c = 0; c < 3; c++) begin
					sd_s2[k][c] <= s_s1[k][c] * d_s1[k][c];
				end
			end
			for (int k = 0; k < 6; k++) begin
				pa_s2[k] <= d_s1[PAIR_I[k]][0] * d_s1[PAIR_J[k]][1];
				pb_s2[k] <= d_s1[PAIR_J[k]][0] * d_s1[PAIR_I[k]][1];
			end

			// minors and lifted column
			for (int i = 0; i < 3; i++) begin
				m_s3[i] <= pm_s2[2*i] - pm_s2[2*i+1];
				rx_s3[i] <= rx_s2[i];
			end
			for (int k = 0; k < 4; k++) begin
				w_s3[k] <= sd_s2[k][0] + sd_s2[k][1] + sd_s2[k][2];
				dz_s3[k] <= dz_s2[k];
			end
			for (int k = 0; k < 6; k++) begin
				p_s3[k] <= pa_s2[k] - pb_s2[k];
			end

			for (int i = 0; i < 3; i++) begin
				t_s4[i] <= rx_s3[i] * m_s3[i];
			end
			for (int k = 0; k < 6; k++) begin
				qa_s4[k] <= dz_s3[PAIR_I[k]] * w_s3[PAIR_J[k]];
				qb_s4[k] <= dz_s3[PAIR_J[k]] * w_s3[PAIR_I[k]];
				p_s4[k] <= p_s3[k];
			end

			pside_s5 <= side_code(det3 < 0, det3 != 0);
			for (int k = 0; k < 6; k++) begin
				q_s5[k] <= qa_s4[k] - qb_s4[k];
				p_s5[k] <= p_s4[k];
			end

			// wide product split into high and low halves of q
			pside_s6 <= pside_s5;
			for (int k = 0; k < 6; k++) begin
				ml_s6[k] <= p_s5[5-k] * $signed({1'b0, q_s5[k][LO-1:0]});
				mh_s6[k] <= p_s5[5-k] * $signed(q_s5[k][QW-1:LO]);
			end

			pside_s7 <= pside_s6;
			for (int k = 0; k < 6; k++) begin
				if (TERM_NEG[k]) begin
					tm_s7[k] <= -((TW'(mh_s6[k]) <<< LO) + TW'(ml_s6[k]));
				end else begin
					tm_s7[k] <= (TW'(mh_s6[k]) <<< LO) + TW'(ml_s6[k]);
				end
			end

			pside_s8 <= pside_s7;
			for (int i = 0; i < 3; i++) begin
				u_s8[i] <= tm_s7[2*i] + tm_s7[2*i+1];
			end

			if (sph_q[8]) begin
				side_q <= side_code(det4 < 0, det4 != 0);
			end else begin
				side_q <= pside_s8;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign side = $signed(side_q);

endmodule
`default_nettype wire

/* rtl/orient_insphere_predicates_core.sv */
// channel | direction | handshake          | payload
// in      | to core   | in_valid/in_stall  | req_type vertex_slot coord_x/y/z corner_a..d
// out     | from core | out_valid/out_stall| side
//
// one item per cycle sustained unless in_stall or out_stall holds the flow
// path: the table read register, a queue entry, eight back-end stages and the output register
// stores write the vertex table at the accepting edge and give no word out
// reset clears handshake and queue state only; the vertex table is not cleared
// out_stall freezes the back end; the front keeps taking words until the queue fills
`default_nettype none
module orient_insphere_predicates_core #(
	parameter int VERTEX_COUNT = 256,
	parameter int COORD_BITS = 11
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [oip_pkg::REQ_W-1:0] req_type,
	input wire logic [oip_pkg::SLOT_W-1:0] vertex_slot,
	input wire logic signed [oip_pkg::COORD_W-1:0] coord_x,
	input wire logic signed [oip_pkg::COORD_W-1:0] coord_y,
	input wire logic signed [oip_pkg::COORD_W-1:0] coord_z,
	input wire logic [oip_pkg::SLOT_W-1:0] corner_a,
	input wire logic [oip_pkg::SLOT_W-1:0] corner_b,
	input wire logic [oip_pkg::SLOT_W-1:0] corner_c,
	input wire logic [oip_pkg::SLOT_W-1:0] corner_d,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [1:0] side
);
	import oip_pkg::*;

	// queue word: sphere flag, point, four corner vertices
	localparam int EW = 15 * COORD_BITS + 1;

	q_stat_t qstat;
	logic push;
	logic pop;
	logic [EW-1:0] push_data;
	logic [EW-1:0] head_data;

	// front: handshake, slot mapping, vertex table reads
	oip_front #(
		.VERTEX_COUNT(VERTEX_COUNT),
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.vertex_slot(vertex_slot),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.coord_z(coord_z),
		.corner_a(corner_a),
		.corner_b(corner_b),
		.corner_c(corner_c),
		.corner_d(corner_d),
		.qstat(qstat),
		.push(push),
		.push_data(push_data)
	);

	// short queue decoupling the two sides
	oip_queue #(
		.WIDTH(EW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(pop),
		.head_data(head_data),
		.qstat(qstat)
	);

	// back: determinant pipe and output register
	oip_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.qstat(qstat),
		.pop(pop),
		.head_data(head_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.side(side)
	);

endmodule
`default_nettype wire
